>>> hw/rtl/rqps_pkg.sv
// Types, constants and codes shared by the ready queue scheduler modules.
`default_nettype none
package rqps_pkg;

    localparam int NUM_TASKS      = 32;
    localparam int NUM_PRIORITIES = 32;
    localparam int TASK_W         = 5;
    localparam int PRIO_W         = 5;
    localparam logic [7:0] LOCK_LIMIT = 8'd250;
    localparam logic [PRIO_W-1:0] LOWEST_RESET = 5'd31;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_LOCK   = 3'd2,
        CMD_UNLOCK = 3'd3,
        CMD_SCHED  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_REFUSED = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_DELETE = 3'd1,
        OP_LOCK   = 3'd2,
        OP_UNLOCK = 3'd3,
        OP_SCHED  = 3'd4,
        OP_BAD    = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0]        command;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] task_priority;
        logic [TASK_W-1:0] current_task;
        logic [PRIO_W-1:0] current_priority;
        logic              system_running;
        logic              in_interrupt;
    } t_in_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [PRIO_W-1:0] highest_ready_priority;
        logic              switch_needed;
        logic [TASK_W-1:0] next_task;
        logic [7:0]        lock_depth_now;
    } t_out_res;

    typedef struct packed {
        t_op     op;
        logic    at_head;
        logic    add_ok;
        logic    task_ok;
        logic    permitted;
        t_in_req req;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_front_ctl;

endpackage
`default_nettype wire

>>> hw/rtl/rqps_front.sv
// Front end: accepts requests, decodes them and queues them for the back end.
`default_nettype none
module rqps_front import rqps_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_req    i_in_req,
    output t_front_ctl      o_ctl,
    input  wire logic       i_pop
);

    t_job       r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    t_job       w_job;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_job.req       = i_in_req;
        w_job.at_head   = i_in_req.task_priority > i_in_req.current_priority;
        w_job.task_ok   = int'(i_in_req.task_id) < NUM_TASKS;
        w_job.add_ok    = w_job.task_ok && (int'(i_in_req.task_priority) < NUM_PRIORITIES);
        w_job.permitted = i_in_req.system_running && !i_in_req.in_interrupt;
        case (i_in_req.command)
            CMD_ADD:    w_job.op = OP_ADD;
            CMD_DELETE: w_job.op = OP_DELETE;
            CMD_LOCK:   w_job.op = OP_LOCK;
            CMD_UNLOCK: w_job.op = OP_UNLOCK;
            CMD_SCHED:  w_job.op = OP_SCHED;
            default:    w_job.op = OP_BAD;
        endcase
    end

    assign o_in_stall = (r_count == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_pop && (r_count != 2'd0);
    assign o_ctl.valid = (r_count != 2'd0);
    assign o_ctl.job   = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) begin
            r_q[r_wptr] <= w_job;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/rqps_back.sv
// Back end: sequencer over the queue link memories, bitmap, lock depth and result register.
`default_nettype none
module rqps_back import rqps_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_front_ctl        i_ctl,
    output logic                   o_pop,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [PRIO_W-1:0] i_cfg_wr_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_res               o_out_res
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD1  = 7'b0000010,
        S_RD2  = 7'b0000100,
        S_WR   = 7'b0001000,
        S_HI   = 7'b0010000,
        S_HD   = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_job   r_job;
    logic   r_sched, n_sched;
    t_status r_status, n_status;
    logic [7:0] r_lock, n_lock;
    logic [NUM_TASKS-1:0]      r_ready, n_ready;
    logic [NUM_PRIORITIES-1:0] r_bitmap, n_bitmap;
    logic [PRIO_W-1:0] r_highest, n_highest;
    logic [PRIO_W-1:0] r_lowest;
    logic [PRIO_W-1:0] r_p;
    logic       r_out_valid;
    t_out_res   r_out_res;

    logic [TASK_W-1:0] m_next [NUM_TASKS];
    logic [TASK_W-1:0] m_prev [NUM_TASKS];
    logic [PRIO_W-1:0] m_prio [NUM_TASKS];
    logic [TASK_W-1:0] m_head [NUM_PRIORITIES];
    logic [TASK_W-1:0] m_tail [NUM_PRIORITIES];

    logic [TASK_W-1:0] r_next_rd, r_prev_rd, r_head_rd, r_tail_rd;
    logic [PRIO_W-1:0] r_prio_rd;

    logic              w_link_re, w_ht_re, w_tail_re;
    logic [PRIO_W-1:0] w_ht_ra;
    logic              w_next_we, w_prev_we, w_prio_we, w_head_we, w_tail_we;
    logic [TASK_W-1:0] w_next_wa, w_next_wd, w_prev_wa, w_prev_wd, w_head_wd, w_tail_wd;
    logic [PRIO_W-1:0] w_hd_wa;
    logic [TASK_W-1:0] w_t;
    logic              w_is_head, w_is_tail, w_any, w_out_free;
    logic [TASK_W-1:0] w_head_task;

    assign w_t        = r_job.req.task_id;
    assign w_any      = |r_bitmap;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_is_head  = (r_head_rd == w_t);
    assign w_is_tail  = (r_tail_rd == w_t);
    assign w_head_task = w_any ? r_head_rd : '0;
    assign o_pop      = (r_state == S_IDLE) && i_ctl.valid;

    always_comb begin
        n_highest = r_lowest;
        for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
            if (r_bitmap[i]) begin
                n_highest = PRIO_W'(i);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_sched  = r_sched;
        n_status = r_status;
        n_lock   = r_lock;
        n_ready  = r_ready;
        n_bitmap = r_bitmap;
        w_link_re = 1'b0;
        w_ht_re   = 1'b0;
        w_tail_re = 1'b0;
        w_ht_ra   = r_job.req.task_priority;
        w_next_we = 1'b0;
        w_prev_we = 1'b0;
        w_prio_we = 1'b0;
        w_head_we = 1'b0;
        w_tail_we = 1'b0;
        w_next_wa = w_t;
        w_next_wd = r_head_rd;
        w_prev_wa = w_t;
        w_prev_wd = r_tail_rd;
        w_head_wd = w_t;
        w_tail_wd = w_t;
        w_hd_wa   = r_p;
        case (r_state)
            S_IDLE: begin
                if (i_ctl.valid) begin
                    n_sched  = 1'b0;
                    n_status = ST_REFUSED;
                    n_state  = S_HD;
                    case (i_ctl.job.op)
                        OP_ADD: begin
                            if (i_ctl.job.add_ok) begin
                                if (r_ready[i_ctl.job.req.task_id]) begin
                                    n_status = ST_IGNORED;
                                end else begin
                                    n_status = ST_DONE;
                                    n_state  = S_RD1;
                                end
                            end
                        end
                        OP_DELETE: begin
                            if (i_ctl.job.task_ok && r_ready[i_ctl.job.req.task_id]) begin
                                n_status = ST_DONE;
                                n_state  = S_RD1;
                            end
                        end
                        OP_LOCK: begin
                            if (i_ctl.job.permitted && r_lock < LOCK_LIMIT) begin
                                n_lock   = r_lock + 8'd1;
                                n_status = ST_DONE;
                            end
                        end
                        OP_UNLOCK: begin
                            if (i_ctl.job.permitted && r_lock != 8'd0) begin
                                n_lock   = r_lock - 8'd1;
                                n_status = ST_DONE;
                                n_sched  = 1'b1;
                            end
                        end
                        OP_SCHED: begin
                            if (i_ctl.job.permitted && r_lock == 8'd0) begin
                                n_status = ST_DONE;
                                n_sched  = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD1: begin
                if (r_job.op == OP_ADD) begin
                    w_ht_re   = 1'b1;
                    w_tail_re = 1'b1;
                    n_state   = S_WR;
                end else begin
                    w_link_re = 1'b1;
                    n_state   = S_RD2;
                end
            end
            S_RD2: begin
                w_ht_re   = 1'b1;
                w_tail_re = 1'b1;
                w_ht_ra   = r_prio_rd;
                n_state   = S_WR;
            end
            S_WR: begin
                n_state = S_HI;
                if (r_job.op == OP_ADD) begin
                    w_prio_we   = 1'b1;
                    n_ready[w_t] = 1'b1;
                    if (!r_bitmap[r_p]) begin
                        w_head_we   = 1'b1;
                        w_tail_we   = 1'b1;
                        n_bitmap[r_p] = 1'b1;
                    end else if (r_job.at_head) begin
                        w_next_we = 1'b1;
                        w_prev_we = 1'b1;
                        w_prev_wa = r_head_rd;
                        w_prev_wd = w_t;
                        w_head_we = 1'b1;
                    end else begin
                        w_prev_we = 1'b1;
                        w_next_we = 1'b1;
                        w_next_wa = r_tail_rd;
                        w_next_wd = w_t;
                        w_tail_we = 1'b1;
                    end
                end else begin
                    n_ready[w_t] = 1'b0;
                    if (w_is_head && w_is_tail) begin
                        n_bitmap[r_p] = 1'b0;
                    end else begin
                        if (w_is_head) begin
                            w_head_we = 1'b1;
                            w_head_wd = r_next_rd;
                        end else begin
                            w_next_we = 1'b1;
                            w_next_wa = r_prev_rd;
                            w_next_wd = r_next_rd;
                        end
                        if (w_is_tail) begin
                            w_tail_we = 1'b1;
                            w_tail_wd = r_prev_rd;
                        end else begin
                            w_prev_we = 1'b1;
                            w_prev_wa = r_next_rd;
                            w_prev_wd = r_prev_rd;
                        end
                    end
                end
            end
            S_HI: begin
                n_state = S_HD;
            end
            S_HD: begin
                w_ht_re = 1'b1;
                w_ht_ra = r_highest;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lock      <= 8'd0;
            r_ready     <= '0;
            r_bitmap    <= '0;
            r_highest   <= LOWEST_RESET;
            r_lowest    <= LOWEST_RESET;
            r_out_valid <= 1'b0;
            r_sched     <= 1'b0;
            r_status    <= ST_DONE;
        end else begin
            r_state   <= n_state;
            r_lock    <= n_lock;
            r_ready   <= n_ready;
            r_bitmap  <= n_bitmap;
            r_highest <= n_highest;
            r_sched   <= n_sched;
            r_status  <= n_status;
            if (i_cfg_wr_en) begin
                r_lowest <= i_cfg_wr_data;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_ctl.job;
            r_p   <= i_ctl.job.req.task_priority;
        end else if (r_state == S_RD2) begin
            r_p <= r_prio_rd;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_res.status                 <= r_status;
            r_out_res.highest_ready_priority <= r_highest;
            r_out_res.switch_needed          <= r_sched && (r_lock == 8'd0) && w_any
                                                && (w_head_task != r_job.req.current_task);
            r_out_res.next_task              <= w_head_task;
            r_out_res.lock_depth_now         <= r_lock;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_link_re) begin
            r_next_rd <= m_next[w_t];
            r_prev_rd <= m_prev[w_t];
            r_prio_rd <= m_prio[w_t];
        end
        if (w_ht_re) begin
            r_head_rd <= m_head[w_ht_ra];
        end
        if (w_tail_re) begin
            r_tail_rd <= m_tail[w_ht_ra];
        end
        if (w_next_we) begin
            m_next[w_next_wa] <= w_next_wd;
        end
        if (w_prev_we) begin
            m_prev[w_prev_wa] <= w_prev_wd;
        end
        if (w_prio_we) begin
            m_prio[w_t] <= r_p;
        end
        if (w_head_we) begin
            m_head[w_hd_wa] <= w_head_wd;
        end
        if (w_tail_we) begin
            m_tail[w_hd_wa] <= w_tail_wd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule
`default_nettype wire

>>> hw/rtl/ready_queue_priority_scheduler.sv
// Top level of the ready queue scheduler: front end, request queue and back end.
`default_nettype none
// The back end sequencer steps each request through reads and writes of the head,
// tail and link memories: lock, unlock, schedule and refused or ignored requests go
// to the head read and output; add reads head and tail, delete reads the links and
// then head and tail, before the writes. A two-entry request queue lets the next
// requests arrive meanwhile. Results leave through an output register in request
// order; lowest_priority writes reach the reported highest priority via registers.
module ready_queue_priority_scheduler import rqps_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_req           i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_res               o_out_res,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [PRIO_W-1:0] i_cfg_wr_data
);

    t_front_ctl w_ctl;
    logic       w_pop;

    rqps_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_ctl      (w_ctl),
        .i_pop      (w_pop)
    );

    rqps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_pop         (w_pop),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_res     (o_out_res)
    );

    a_lock_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_res.lock_depth_now <= LOCK_LIMIT))
        else $error("lock depth beyond limit");

    a_switch_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_res.switch_needed) |->
            (o_out_res.status == ST_DONE && o_out_res.lock_depth_now == 8'd0))
        else $error("switch requested on refused request or while locked");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_ctl.valid)
        else $error("back end took a request from an empty queue");

endmodule
`default_nettype wire
